/* rtl/uks_pkg.sv */
// Shared types and codes for the unique-key stack.
// Used by unique_key_stack; depends on nothing else.
package uks_pkg;

    // Default number of entries in the stack store.
    localparam int STACK_DEPTH_DEF = 64;

    // Widths of the stream fields.
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 7;

    // Command codes carried on s_tuser.
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    // Status codes carried on m_tuser.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TOP,
        S_DONE
    } state_t;

endpackage

/* rtl/unique_key_stack.sv */
// Bounded LIFO stack of key/data pairs with a duplicate-key check on push.
// Depends on uks_pkg for codes, widths and the state type.
//
//  channel | dir | tdata (low bit up)                                   | tuser
//  --------+-----+------------------------------------------------------+-------------
//  s_      | in  | push_key[31:0], push_data[63:32], zeros[71:64]       | command[1:0]
//  m_      | out | out_key[31:0], out_data[63:32], is_empty[64],        | status[1:0]
//          |     | entry_count[71:65]                                   |
//
// A push scans the stored keys, one key memory read per cycle, and stops the scan early
// on a duplicate. A pop or peek with entries reads the top entry before its result is formed.
// Reset clears the fill level and the control state; the memories are not cleared.
// A new item is accepted while a result waits in the output register; its own
// result is held until that register has been taken.
module unique_key_stack #(
    parameter int STACK_DEPTH = uks_pkg::STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // push_key[31:0], push_data[63:32], zero pad[71:64]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_key[31:0], out_data[63:32], is_empty[64],
                                   // entry_count[71:65]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int WW     = uks_pkg::WORD_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    // Stack storage, entry 0 at the bottom.
    logic [WW-1:0] key_mem  [STACK_DEPTH];
    logic [WW-1:0] data_mem [STACK_DEPTH];
    logic [WW-1:0] rd_key_reg;
    logic [WW-1:0] rd_data_reg;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    uks_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             chk_reg, chk_next;

    logic [uks_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [WW-1:0]                key_reg, key_next;
    logic [WW-1:0]                data_reg, data_next;
    logic [uks_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [WW-1:0]                okey_reg, okey_next;
    logic [WW-1:0]                odata_reg, odata_next;

    logic        m_valid_reg, m_valid_next;
    logic [71:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    logic                    out_free;
    logic                    s_accept;
    logic [CNT_W+6:0]        count_ext;

    assign s_tready = (state_reg == uks_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Entry count after the operation, low seven bits of the fill level.
    assign count_ext = {7'd0, fill_next};

    // Memory ports: one registered read, one write.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_data_reg <= data_mem[rd_addr];
        end
        if (wr_en) begin
            key_mem[fill_reg[ADDR_W-1:0]]  <= key_reg;
            data_mem[fill_reg[ADDR_W-1:0]] <= data_reg;
        end
    end

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= uks_pkg::S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
            chk_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            chk_reg     <= chk_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        data_reg     <= data_next;
        status_reg   <= status_next;
        okey_reg     <= okey_next;
        odata_reg    <= odata_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // Sequencer: next state, memory accesses and result formation.
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        scan_idx_next = scan_idx_reg;
        chk_next      = 1'b0;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        data_next     = data_reg;
        status_next   = status_reg;
        okey_next     = okey_reg;
        odata_next    = odata_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;

        unique case (state_reg)
            uks_pkg::S_IDLE: begin
                if (s_accept) begin
                    cmd_next      = s_tuser;
                    key_next      = s_tdata[WW-1:0];
                    data_next     = s_tdata[2*WW-1:WW];
                    okey_next     = '0;
                    odata_next    = '0;
                    status_next   = uks_pkg::ST_OK;
                    scan_idx_next = '0;
                    unique case (s_tuser) inside
                        uks_pkg::CMD_PUSH: begin
                            state_next = uks_pkg::S_SCAN;
                        end
                        uks_pkg::CMD_POP, uks_pkg::CMD_PEEK: begin
                            if (fill_reg == '0) begin
                                status_next = uks_pkg::ST_UNDER;
                                state_next  = uks_pkg::S_DONE;
                            end else begin
                                // Fetch the top entry.
                                rd_en      = 1'b1;
                                rd_addr    = ADDR_W'(fill_reg - ONE_CNT);
                                state_next = uks_pkg::S_TOP;
                            end
                        end
                        default: begin
                            state_next = uks_pkg::S_DONE;
                        end
                    endcase
                end
            end

            uks_pkg::S_SCAN: begin
                // Issue one key read per cycle and check the one read last cycle.
                rd_en         = (scan_idx_reg < fill_reg);
                rd_addr       = scan_idx_reg[ADDR_W-1:0];
                chk_next      = rd_en;
                scan_idx_next = rd_en ? scan_idx_reg + ONE_CNT : scan_idx_reg;
                if (chk_reg && (rd_key_reg == key_reg)) begin
                    status_next = uks_pkg::ST_DUP;
                    chk_next    = 1'b0;
                    state_next  = uks_pkg::S_DONE;
                end else if (!rd_en && !chk_reg) begin
                    status_next = (fill_reg == DEPTH_CNT) ? uks_pkg::ST_OVER
                                                          : uks_pkg::ST_OK;
                    state_next  = uks_pkg::S_DONE;
                end
            end

            uks_pkg::S_TOP: begin
                okey_next  = rd_key_reg;
                odata_next = rd_data_reg;
                state_next = uks_pkg::S_DONE;
            end

            uks_pkg::S_DONE: begin
                if (out_free) begin
                    // Commit the stack update and load the result.
                    if (status_reg == uks_pkg::ST_OK) begin
                        if (cmd_reg == uks_pkg::CMD_PUSH) begin
                            wr_en     = 1'b1;
                            fill_next = fill_reg + ONE_CNT;
                        end else if (cmd_reg == uks_pkg::CMD_POP) begin
                            fill_next = fill_reg - ONE_CNT;
                        end
                    end
                    m_valid_next = 1'b1;
                    m_tuser_next = status_reg;
                    m_tdata_next = {count_ext[6:0], (fill_next == '0), odata_reg, okey_reg};
                    state_next   = uks_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = uks_pkg::S_IDLE;
            end
        endcase
    end

endmodule
